>>> sv/pfde_pkg.sv
// Package of the page framebuffer draw engine.
// Holds the word types, mode codes, command kinds and the 5x7 font table.
// Has no dependencies.
package pfde_pkg;

    localparam int PAGE_ROWS   = 8;
    localparam int CELL_HEIGHT = 8;
    localparam int FONT_COLS   = 5;
    localparam int ADDR_BITS   = 11;
    localparam int COUNT_BITS  = 12;

    localparam logic [2:0] MODE_PIXEL     = 3'd0;
    localparam logic [2:0] MODE_GLYPH     = 3'd1;
    localparam logic [2:0] MODE_FILL      = 3'd2;
    localparam logic [2:0] MODE_READ      = 3'd3;
    localparam logic [2:0] MODE_CLR_DIRTY = 3'd4;
    localparam logic [2:0] MODE_MARK_ALL  = 3'd5;

    localparam logic [1:0] COLOR_BLACK  = 2'd0;
    localparam logic [1:0] COLOR_WHITE  = 2'd1;
    localparam logic [1:0] COLOR_INVERT = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [7:0] FONT_FIRST    = 8'd32;
    localparam logic [7:0] FONT_LAST     = 8'd126;
    localparam logic [6:0] FONT_FALLBACK = 7'd31;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [2:0] page_index;
        logic [1:0] color;
        logic [7:0] glyph_code;
    } item_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_byte;
        logic       changed;
        logic [7:0] dirty_mask;
    } result_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_PIXEL,
        K_GLYPH,
        K_FILL,
        K_READ,
        K_CLR_DIRTY,
        K_MARK_ALL
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic                   status;
        logic [ADDR_BITS-1:0]   addr;
        logic [2:0]             page;
        logic [2:0]             bit_sel;
        logic [1:0]             color;
        logic [6:0]             glyph;
        logic [7:0]             width;
        logic [COUNT_BITS-1:0]  count;
        logic [7:0]             mark_mask;
    } cmd_t;

    localparam logic [7:0] FONT_ROM [95][5] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h5F,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12},'{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00},'{8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14},'{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00},'{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E},'{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46},'{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10},'{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30},'{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h79,8'h41,8'h3E},'{8'h7E,8'h11,8'h11,8'h11,8'h7E},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36},'{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C},'{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01},'{8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F},'{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01},'{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40},'{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F},'{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06},'{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46},'{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01},'{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F},'{8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20},'{8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h7F,8'h48,8'h44,8'h44,8'h38},'{8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h38,8'h44,8'h44,8'h48,8'h7F},'{8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h08,8'h7E,8'h09,8'h01,8'h02},'{8'h0C,8'h52,8'h52,8'h52,8'h3E},
        '{8'h7F,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h20,8'h40,8'h44,8'h3D,8'h00},'{8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7F,8'h40,8'h00},'{8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h7C,8'h08,8'h04,8'h04,8'h78},'{8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h7C,8'h14,8'h14,8'h14,8'h08},'{8'h08,8'h14,8'h14,8'h18,8'h7C},
        '{8'h7C,8'h08,8'h04,8'h04,8'h08},'{8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h04,8'h3F,8'h44,8'h40,8'h20},'{8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h1C,8'h20,8'h40,8'h20,8'h1C},'{8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h0C,8'h50,8'h50,8'h50,8'h3C},
        '{8'h44,8'h64,8'h54,8'h4C,8'h44},'{8'h00,8'h08,8'h36,8'h41,8'h00},
        '{8'h00,8'h00,8'h7F,8'h00,8'h00},'{8'h00,8'h41,8'h36,8'h08,8'h00},
        '{8'h08,8'h04,8'h08,8'h10,8'h08}
    };

endpackage

>>> sv/pfde_front.sv
// Front end of the page framebuffer draw engine.
// Checks each item against the panel size and turns it into a command.
// Depends on pfde_pkg.
module pfde_front #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int CELL_WIDTH = 6
) (
    input  pfde_pkg::item_t item,
    input  logic [7:0]      panel_width,
    input  logic [6:0]      panel_height,
    output pfde_pkg::cmd_t  cmd
);

    logic [7:0]  used_w;
    logic [6:0]  used_h;
    logic [3:0]  pages;
    logic [11:0] page_base;
    logic [11:0] pix_base;
    logic [11:0] cell_base;
    logic [11:0] cell_end;
    logic [11:0] cell_col;
    logic [6:0]  glyph_idx;
    logic [7:0]  mark;

    always_comb
    begin
        used_w = ({1'b0, panel_width} > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : panel_width;
        used_h = (panel_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : panel_height;
        pages = used_h[6:3];
        page_base = 12'(item.page_index) * 12'(used_w);
        pix_base = 12'(item.y_pos[2:0]) * 12'(used_w);
        cell_col = 12'(item.x_pos) * 12'(CELL_WIDTH);
        cell_end = cell_col + 12'(CELL_WIDTH);
        cell_base = pix_base + cell_col;
        mark = (pages >= 4'd8) ? 8'hFF : 8'((9'd1 << pages) - 9'd1);
        if (item.glyph_code >= pfde_pkg::FONT_FIRST && item.glyph_code <= pfde_pkg::FONT_LAST)
        begin
            glyph_idx = 7'(item.glyph_code - pfde_pkg::FONT_FIRST);
        end
        else
        begin
            glyph_idx = pfde_pkg::FONT_FALLBACK;
        end

        cmd = '0;
        cmd.kind = pfde_pkg::K_NONE;
        cmd.status = 1'b1;
        cmd.color = item.color;
        cmd.glyph = glyph_idx;
        cmd.width = used_w;
        cmd.mark_mask = mark;
        cmd.bit_sel = item.y_pos[2:0];
        cmd.count = 12'(pages) * 12'(used_w);
        case (item.mode)
            pfde_pkg::MODE_PIXEL:
            begin
                cmd.page = item.y_pos[5:3];
                cmd.addr = pfde_pkg::ADDR_BITS'(12'(item.y_pos[5:3]) * 12'(used_w)
                           + 12'(item.x_pos));
                if (item.x_pos < used_w && {3'b000, item.y_pos[7:3]} < {4'b0000, pages})
                begin
                    cmd.kind = pfde_pkg::K_PIXEL;
                    cmd.status = 1'b0;
                end
            end
            pfde_pkg::MODE_GLYPH:
            begin
                cmd.page = item.y_pos[2:0];
                cmd.addr = pfde_pkg::ADDR_BITS'(cell_base);
                if (cell_end <= 12'(used_w) && item.y_pos < {4'b0000, pages})
                begin
                    cmd.kind = pfde_pkg::K_GLYPH;
                    cmd.status = 1'b0;
                end
            end
            pfde_pkg::MODE_FILL:
            begin
                cmd.kind = pfde_pkg::K_FILL;
                cmd.status = 1'b0;
            end
            pfde_pkg::MODE_READ:
            begin
                cmd.page = item.page_index;
                cmd.addr = pfde_pkg::ADDR_BITS'(page_base + 12'(item.x_pos));
                if (item.x_pos < used_w && {1'b0, item.page_index} < pages)
                begin
                    cmd.kind = pfde_pkg::K_READ;
                    cmd.status = 1'b0;
                end
            end
            pfde_pkg::MODE_CLR_DIRTY:
            begin
                cmd.page = item.page_index;
                if ({1'b0, item.page_index} < pages)
                begin
                    cmd.kind = pfde_pkg::K_CLR_DIRTY;
                    cmd.status = 1'b0;
                end
            end
            pfde_pkg::MODE_MARK_ALL:
            begin
                cmd.kind = pfde_pkg::K_MARK_ALL;
                cmd.status = 1'b0;
            end
            default:
            begin
                cmd.kind = pfde_pkg::K_NONE;
            end
        endcase
    end

endmodule

>>> sv/pfde_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on pfde_pkg.
module pfde_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pfde_pkg::cmd_t wr_cmd,
    output logic           q_full,
    input  logic           rd_en,
    output pfde_pkg::cmd_t rd_cmd,
    output logic           q_empty
);

    pfde_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

>>> sv/pfde_back.sv
// Back end of the page framebuffer draw engine.
// Owns the frame store and dirty mask; runs pixel, glyph and fill commands as byte read-modify-writes.
// Depends on pfde_pkg.
module pfde_back #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int CELL_WIDTH = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pfde_pkg::cmd_t    q_cmd,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              clearing,
    output pfde_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT / pfde_pkg::PAGE_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_MODIFY,
        S_DONE
    } state_t;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    state_t                         state_reg, state_next;
    pfde_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic [7:0]                     col_reg, col_next;
    logic [2:0]                     page_reg, page_next;
    logic [pfde_pkg::COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                           changed_reg, changed_next;
    logic [7:0]                     rd_reg, rd_next;
    logic [7:0]                     dirty_reg, dirty_next;
    logic                           out_valid_reg, out_valid_next;
    pfde_pkg::result_t              out_reg, out_next;

    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic [7:0]    new_byte;
    logic [7:0]    font_bits;
    logic [7:0]    bit_mask;
    logic          last_byte;
    logic          out_free;

    assign clearing = (state_reg == S_CLEAR);
    assign empty    = ~out_valid_reg;
    assign result   = out_reg;
    assign out_free = ~out_valid_reg | pop;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_comb
    begin
        bit_mask = 8'd1 << cmd_reg.bit_sel;
        font_bits = (col_reg < 8'(pfde_pkg::FONT_COLS))
                    ? pfde_pkg::FONT_ROM[cmd_reg.glyph][col_reg[2:0]] : 8'h00;
        case (cmd_reg.kind)
            pfde_pkg::K_PIXEL:
            begin
                if (cmd_reg.color == pfde_pkg::COLOR_WHITE)
                begin
                    new_byte = rdata_reg | bit_mask;
                end
                else if (cmd_reg.color == pfde_pkg::COLOR_BLACK)
                begin
                    new_byte = rdata_reg & ~bit_mask;
                end
                else
                begin
                    new_byte = rdata_reg ^ bit_mask;
                end
            end
            pfde_pkg::K_GLYPH:
            begin
                if (cmd_reg.color == pfde_pkg::COLOR_BLACK)
                begin
                    new_byte = ~font_bits;
                end
                else if (cmd_reg.color == pfde_pkg::COLOR_WHITE)
                begin
                    new_byte = font_bits;
                end
                else
                begin
                    new_byte = ~rdata_reg & font_bits;
                end
            end
            pfde_pkg::K_FILL:
            begin
                if (cmd_reg.color == pfde_pkg::COLOR_INVERT)
                begin
                    new_byte = ~rdata_reg;
                end
                else if (cmd_reg.color == pfde_pkg::COLOR_WHITE)
                begin
                    new_byte = 8'hFF;
                end
                else
                begin
                    new_byte = 8'h00;
                end
            end
            default:
            begin
                new_byte = rdata_reg;
            end
        endcase

        case (cmd_reg.kind)
            pfde_pkg::K_GLYPH: last_byte = (col_reg == 8'(CELL_WIDTH - 1));
            pfde_pkg::K_FILL:  last_byte = (cnt_reg + 1'b1 == cmd_reg.count);
            default:           last_byte = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        col_next       = col_reg;
        page_next      = page_reg;
        cnt_next       = cnt_reg;
        changed_next   = changed_reg;
        rd_next        = rd_reg;
        dirty_next     = dirty_reg;
        out_valid_next = out_valid_reg & ~pop;
        out_next       = out_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = 8'h00;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    addr_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_cmd;
                    addr_next = q_cmd.addr[AW-1:0];
                    col_next = 8'd0;
                    page_next = q_cmd.page;
                    cnt_next = '0;
                    changed_next = 1'b0;
                    rd_next = 8'h00;
                    case (q_cmd.kind)
                        pfde_pkg::K_PIXEL, pfde_pkg::K_GLYPH, pfde_pkg::K_READ:
                        begin
                            state_next = S_ISSUE;
                        end
                        pfde_pkg::K_FILL:
                        begin
                            addr_next = '0;
                            page_next = 3'd0;
                            state_next = (q_cmd.count == '0) ? S_DONE : S_ISSUE;
                        end
                        pfde_pkg::K_CLR_DIRTY:
                        begin
                            dirty_next = dirty_reg & ~(8'd1 << q_cmd.page);
                            state_next = S_DONE;
                        end
                        pfde_pkg::K_MARK_ALL:
                        begin
                            dirty_next = q_cmd.mark_mask;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                if (cmd_reg.kind == pfde_pkg::K_READ)
                begin
                    rd_next = rdata_reg;
                end
                else if (new_byte != rdata_reg)
                begin
                    mem_we = 1'b1;
                    mem_wdata = new_byte;
                    changed_next = 1'b1;
                    dirty_next = dirty_reg | (8'd1 << page_reg);
                end
                if (last_byte)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ISSUE;
                    addr_next = addr_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cmd_reg.kind == pfde_pkg::K_FILL && col_reg == cmd_reg.width - 8'd1)
                    begin
                        col_next = 8'd0;
                        page_next = page_reg + 3'd1;
                    end
                    else
                    begin
                        col_next = col_reg + 8'd1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.status = cmd_reg.status;
                    out_next.read_byte = rd_reg;
                    out_next.changed = changed_reg;
                    out_next.dirty_mask = dirty_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmd_reg       <= '0;
            addr_reg      <= '0;
            col_reg       <= 8'd0;
            page_reg      <= 3'd0;
            cnt_reg       <= '0;
            changed_reg   <= 1'b0;
            rd_reg        <= 8'h00;
            dirty_reg     <= 8'h00;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            addr_reg      <= addr_next;
            col_reg       <= col_next;
            page_reg      <= page_next;
            cnt_reg       <= cnt_next;
            changed_reg   <= changed_next;
            rd_reg        <= rd_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

>>> sv/page_framebuffer_draw_engine_top.sv
// Page framebuffer draw engine: a page-organized monochrome frame store with dirty pages.
// Pixel items touch one byte, glyph items CELL_WIDTH bytes and fill items pages*width bytes,
// each byte a read-modify-write on the single store port. One item is carried out at a time;
// two more may wait in the queue. Reset clears control state and the dirty mask, then sweeps
// zeros through every byte of the frame store while full stays high.
module page_framebuffer_draw_engine_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int CELL_WIDTH = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pfde_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output pfde_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    logic [7:0]     width_reg;
    logic [6:0]     height_reg;
    pfde_pkg::cmd_t front_cmd;
    pfde_pkg::cmd_t q_cmd;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           clearing;
    logic           accept;

    assign cfg_ready = 1'b1;
    assign full      = q_full | clearing;
    assign accept    = push & ~full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == pfde_pkg::CFG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == pfde_pkg::CFG_HEIGHT)
            begin
                height_reg <= cfg_data[6:0];
            end
        end
    end

    pfde_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CELL_WIDTH (CELL_WIDTH)
    ) u_front (
        .item         (item),
        .panel_width  (width_reg),
        .panel_height (height_reg),
        .cmd          (front_cmd)
    );

    pfde_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_cmd),
        .q_empty (q_empty)
    );

    pfde_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CELL_WIDTH (CELL_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_cmd    (q_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .clearing (clearing),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
